[rtl/cpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DUE_W       = 64;
    localparam int WHOLE_W     = DUE_W - FRAC_BITS;
    localparam int CREDIT_W    = WHOLE_W + 1;
    localparam int CNT_W       = 48;
    localparam int LIM_W       = 24;
    localparam int RATE_W      = 24;
    localparam int BURST_W     = 16;
    localparam int LATE_W      = 40;
    localparam int RES_W       = 32;
    localparam int LATE_WIDE_W = LIM_W + FRAC_BITS;
    localparam int LATE_EXT_W  = (LATE_WIDE_W > LATE_W) ? LATE_WIDE_W : LATE_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    localparam logic [LATE_W-1:0] LATE_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RESYNC  = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [BURST_W-1:0] max_burst;
    } in_word_t;

    typedef struct packed {
        logic [BURST_W-1:0] granted;
        logic               debt_forgiven;
        logic [CNT_W-1:0]   issued_total;
        logic [LIM_W-1:0]   peak_backlog;
        logic [LATE_W-1:0]  peak_lateness;
        logic [CNT_W-1:0]   grant_slots;
        logic [RES_W-1:0]   forgive_count;
    } out_word_t;

    typedef struct packed {
        logic              enable;
        logic [RATE_W-1:0] rate_per_tick;
        logic [LIM_W-1:0]  catch_up_limit;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/cpp_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpp_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cpp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cpp_pkg::cfg_t                         cfg
);
    import cpp_pkg::*;

    logic              enable_reg, enable_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [LIM_W-1:0]  limit_reg, limit_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        enable_next = enable_reg;
        rate_next   = rate_reg;
        limit_next  = limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ENABLE: enable_next = cfg_data[0];
                CFG_RATE:   rate_next   = cfg_data[RATE_W-1:0];
                CFG_LIMIT:  limit_next  = cfg_data[LIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            rate_reg   <= '0;
            limit_reg  <= LIM_W'(1);
        end
        else
        begin
            enable_reg <= enable_next;
            rate_reg   <= rate_next;
            limit_reg  <= limit_next;
        end
    end

    assign cfg.enable         = enable_reg;
    assign cfg.rate_per_tick  = rate_reg;
    assign cfg.catch_up_limit = limit_reg;

endmodule

`default_nettype wire

[rtl/cpp_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpp_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cpp_pkg::cfg_t     cfg,
    input  wire logic              go,
    input  wire cpp_pkg::in_word_t item,
    output cpp_pkg::out_word_t     res
);
    import cpp_pkg::*;

    logic [DUE_W-1:0]  due_reg, due_next;
    logic [CNT_W-1:0]  issued_reg, issued_next;
    logic [LIM_W-1:0]  backlog_reg, backlog_next;
    logic [LATE_W-1:0] late_reg, late_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic [RES_W-1:0]  resync_reg, resync_next;

    logic [WHOLE_W-1:0]     due_whole;
    logic [CREDIT_W-1:0]    credit;
    logic                   credit_neg;
    logic [LIM_W-1:0]       limit_eff;
    logic [BURST_W-1:0]     burst_eff;
    logic                   active;
    logic                   forgive;
    logic                   has_credit;
    logic [LIM_W-1:0]       credit_sel;
    logic [CNT_W-1:0]       issued_clamp;
    logic [CNT_W-1:0]       issued_base;
    logic [BURST_W-1:0]     grant_w;
    logic [LATE_WIDE_W-1:0] late_wide;
    logic [LATE_EXT_W-1:0]  late_ext;
    logic [LATE_W-1:0]      late_sat;

    logic [BURST_W-1:0] acq_granted;
    logic               acq_forgiven;
    logic [CNT_W-1:0]   acq_issued;
    logic [LIM_W-1:0]   acq_backlog;
    logic [LATE_W-1:0]  acq_late;
    logic [CNT_W-1:0]   acq_slot;
    logic [RES_W-1:0]   acq_resync;

    // credit and grant for an acquire against the current state
    always_comb
    begin
        due_whole    = due_reg[DUE_W-1:FRAC_BITS];
        credit       = CREDIT_W'(due_whole) - CREDIT_W'(issued_reg);
        credit_neg   = credit[CREDIT_W-1];
        limit_eff    = (cfg.catch_up_limit == '0) ? LIM_W'(1) : cfg.catch_up_limit;
        burst_eff    = (item.max_burst == '0) ? BURST_W'(1) : item.max_burst;
        active       = cfg.enable && (cfg.rate_per_tick != '0);
        forgive      = active && !credit_neg
                       && (credit[WHOLE_W-1:0] > WHOLE_W'(limit_eff));
        has_credit   = forgive || (!credit_neg && (credit != '0));
        credit_sel   = forgive ? limit_eff : credit[LIM_W-1:0];
        issued_clamp = CNT_W'(due_whole - WHOLE_W'(limit_eff));
        issued_base  = forgive ? issued_clamp : issued_reg;
        grant_w      = (credit_sel > LIM_W'(burst_eff)) ? burst_eff
                                                        : credit_sel[BURST_W-1:0];
        // due minus issued in fixed point is credit with the fraction below it
        late_wide    = {credit_sel, due_reg[FRAC_BITS-1:0]};
        late_ext     = LATE_EXT_W'(late_wide);
        late_sat     = (late_ext > LATE_EXT_W'(LATE_MAX)) ? LATE_MAX
                                                         : late_ext[LATE_W-1:0];

        acq_granted  = '0;
        acq_forgiven = forgive;
        acq_issued   = issued_reg;
        acq_backlog  = backlog_reg;
        acq_late     = late_reg;
        acq_slot     = slot_reg;
        acq_resync   = forgive ? resync_reg + RES_W'(1) : resync_reg;
        if (active)
        begin
            acq_issued = issued_base;
            if (has_credit)
            begin
                acq_granted = grant_w;
                acq_issued  = issued_base + CNT_W'(grant_w);
                acq_slot    = slot_reg + CNT_W'(1);
                if (credit_sel > backlog_reg)
                begin
                    acq_backlog = credit_sel;
                end
                if (late_sat > late_reg)
                begin
                    acq_late = late_sat;
                end
            end
        end
    end

    always_comb
    begin
        res.granted       = acq_granted;
        res.debt_forgiven = acq_forgiven;
        res.issued_total  = acq_issued;
        res.peak_backlog  = acq_backlog;
        res.peak_lateness = acq_late;
        res.grant_slots   = acq_slot;
        res.forgive_count = acq_resync;
    end

    always_comb
    begin
        due_next     = due_reg;
        issued_next  = issued_reg;
        backlog_next = backlog_reg;
        late_next    = late_reg;
        slot_next    = slot_reg;
        resync_next  = resync_reg;
        if (go)
        begin
            case (item.op)
                OP_TICK:
                begin
                    due_next = due_reg + DUE_W'(cfg.rate_per_tick);
                end
                OP_ACQUIRE:
                begin
                    issued_next  = acq_issued;
                    backlog_next = acq_backlog;
                    late_next    = acq_late;
                    slot_next    = acq_slot;
                    resync_next  = acq_resync;
                end
                OP_RESYNC:
                begin
                    due_next    = '0;
                    issued_next = '0;
                end
                OP_RESTART:
                begin
                    due_next     = '0;
                    issued_next  = '0;
                    backlog_next = '0;
                    late_next    = '0;
                    slot_next    = '0;
                    resync_next  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_reg     <= '0;
            issued_reg  <= '0;
            backlog_reg <= '0;
            late_reg    <= '0;
            slot_reg    <= '0;
            resync_reg  <= '0;
        end
        else
        begin
            due_reg     <= due_next;
            issued_reg  <= issued_next;
            backlog_reg <= backlog_next;
            late_reg    <= late_next;
            slot_reg    <= slot_next;
            resync_reg  <= resync_next;
        end
    end

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && (item.op == OP_RESTART) |=>
            (due_reg == '0) && (slot_reg == '0) && (resync_reg == '0) && (late_reg == '0))
        else $error("restart left pacer state nonzero");

    a_grant_counts_slot: assert property (@(posedge clk) disable iff (!rst_n)
        go && (item.op == OP_ACQUIRE) && (res.granted != '0) |=>
            slot_reg == $past(slot_reg) + CNT_W'(1))
        else $error("grant did not advance the slot count");

    a_forgive_counts: assert property (@(posedge clk) disable iff (!rst_n)
        go && (item.op == OP_ACQUIRE) && res.debt_forgiven |=>
            resync_reg == $past(resync_reg) + RES_W'(1))
        else $error("forgiven debt did not advance the clamp count");

endmodule

`default_nettype wire

[rtl/credit_packet_pacer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// an accepted word is held in the input register; an acquire's result is then loaded into the result register
// throughput: one word per cycle, limited only by stall on the result side
// the credit, clamp and grant path is combinational logic between input and result registers
// reset: async active low, clears pacer state and word valid flags
// reset: enable 0, rate 0, catch-up limit 1
module credit_packet_pacer_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire cpp_pkg::in_word_t                in_word,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output cpp_pkg::out_word_t                    out_word,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cpp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cpp_pkg::*;

    cfg_t      cfg;
    out_word_t res;

    logic      in_valid_reg, in_valid_next;
    in_word_t  in_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg;

    logic      is_acq;
    logic      blocked;
    logic      go;

    cpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpp_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .go    (go),
        .item  (in_word_reg),
        .res   (res)
    );

    always_comb
    begin
        is_acq   = (in_word_reg.op == OP_ACQUIRE);
        // an acquire waits only while the result register is full and stalled
        blocked  = in_valid_reg && is_acq && out_valid_reg && out_stall;
        go       = in_valid_reg && !blocked;
        in_stall = blocked;

        in_valid_next = blocked ? in_valid_reg : in_valid;

        out_valid_next = out_valid_reg;
        if (go && is_acq)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !blocked)
        begin
            in_word_reg <= in_word;
        end
        if (go && is_acq)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        blocked |=> in_valid_reg && $stable(in_word_reg))
        else $error("blocked acquire was dropped or changed");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        go && is_acq |=> out_valid_reg && (out_word_reg == $past(res)))
        else $error("acquire result not captured");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(go && is_acq))
        else $error("result appeared without an acquire");

endmodule

`default_nettype wire

[tb/credit_packet_pacer_unit_tb.sv]
`timescale 1ns / 1ps

module credit_packet_pacer_unit_tb;

    import cpp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_WORDS    = 62;
    localparam int REPORT_LIMIT   = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // pacer shadow state
    cfg_t             pacer_cfg;
    logic [DUE_W-1:0] due_acc;
    logic [CNT_W-1:0] issued_cnt;
    logic [LIM_W-1:0] peak_bl;
    logic [LATE_W-1:0] peak_late;
    logic [CNT_W-1:0] slot_cnt;
    logic [RES_W-1:0] forgive_cnt;

    out_word_t grant_queue[$];
    out_word_t want;

    int  mismatches;
    int  idle_cycles;
    int  hold_cycles;
    bit  send_gaps;
    bit  recv_gaps;

    credit_packet_pacer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic pace_word(input in_word_t w);
        longint credit;
        longint lim;
        longint burst;
        logic [DUE_W-1:0] late;
        out_word_t r;
        case (op_t'(w.op))
            OP_TICK:
            begin
                due_acc = due_acc + DUE_W'(pacer_cfg.rate_per_tick);
            end
            OP_RESYNC:
            begin
                due_acc    = '0;
                issued_cnt = '0;
            end
            OP_RESTART:
            begin
                due_acc     = '0;
                issued_cnt  = '0;
                peak_bl     = '0;
                peak_late   = '0;
                slot_cnt    = '0;
                forgive_cnt = '0;
            end
            default:
            begin
                r = '0;
                if (pacer_cfg.enable && pacer_cfg.rate_per_tick != '0)
                begin
                    credit = longint'(due_acc[DUE_W-1:FRAC_BITS]) - longint'(issued_cnt);
                    lim    = longint'(pacer_cfg.catch_up_limit);
                    if (lim == 0)
                        lim = 1;
                    burst = longint'(w.max_burst);
                    if (burst == 0)
                        burst = 1;
                    if (credit > lim)
                    begin
                        issued_cnt      = due_acc[DUE_W-1:FRAC_BITS] - CNT_W'(lim);
                        credit          = lim;
                        forgive_cnt     = forgive_cnt + 1'b1;
                        r.debt_forgiven = 1'b1;
                    end
                    if (credit >= 1)
                    begin
                        late = due_acc - {issued_cnt, {FRAC_BITS{1'b0}}};
                        if (late > DUE_W'(LATE_MAX))
                            late = DUE_W'(LATE_MAX);
                        if (late[LATE_W-1:0] > peak_late)
                            peak_late = late[LATE_W-1:0];
                        if (LIM_W'(credit) > peak_bl)
                            peak_bl = LIM_W'(credit);
                        if (credit > burst)
                            credit = burst;
                        r.granted  = BURST_W'(credit);
                        issued_cnt = issued_cnt + CNT_W'(credit);
                        slot_cnt   = slot_cnt + 1'b1;
                    end
                end
                r.issued_total  = issued_cnt;
                r.peak_backlog  = peak_bl;
                r.peak_lateness = peak_late;
                r.grant_slots   = slot_cnt;
                r.forgive_count = forgive_cnt;
                grant_queue.push_back(r);
            end
        endcase
    endtask

    function automatic logic [BURST_W-1:0] draw_burst();
        if ($urandom_range(0, 3) == 0)
            return BURST_W'($urandom());
        return BURST_W'($urandom_range(0, 8));
    endfunction

    task automatic push_word(input op_t op, input logic [BURST_W-1:0] burst);
        in_word_t w;
        int gap;
        w.op        = op;
        w.max_burst = burst;
        gap = send_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        pace_word(w);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ENABLE: pacer_cfg.enable         = data[0];
            CFG_RATE:   pacer_cfg.rate_per_tick  = RATE_W'(data);
            CFG_LIMIT:  pacer_cfg.catch_up_limit = LIM_W'(data);
            default:    ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic en, input logic [RATE_W-1:0] rate,
                              input logic [LIM_W-1:0] lim);
        logic [CFG_DATA_W-1:0] en_data;
        // upper bits of the enable write are don't-care
        en_data    = CFG_DATA_W'($urandom());
        en_data[0] = en;
        write_reg(CFG_ENABLE, en_data);
        write_reg(CFG_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (grant_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_disabled();
        push_word(OP_ACQUIRE, '0);
        push_word(OP_ACQUIRE, '1);
        push_word(OP_TICK, 16'h5A5A);
        settle();
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
        set_config(1'b1, '0, '1);
        push_word(OP_TICK, 16'hA5A5);
        push_word(OP_ACQUIRE, 16'd4);
        settle();
    endtask

    task automatic test_grants();
        set_config(1'b1, '1, '1);
        push_word(OP_TICK, '0);
        push_word(OP_ACQUIRE, '0);
        push_word(OP_ACQUIRE, 16'd3);
        push_word(OP_ACQUIRE, '1);
        push_word(OP_ACQUIRE, 16'd1);
        settle();
    endtask

    task automatic test_forgive();
        set_config(1'b1, '1, '0);
        push_word(OP_TICK, '0);
        push_word(OP_ACQUIRE, '1);
        settle();
        set_config(1'b1, '1, 24'd2);
        push_word(OP_TICK, '0);
        push_word(OP_TICK, '0);
        push_word(OP_ACQUIRE, 16'd1);
        settle();
    endtask

    task automatic test_fraction();
        set_config(1'b1, 24'h00_8000, 24'd4);
        push_word(OP_TICK, '0);
        push_word(OP_ACQUIRE, '0);
        push_word(OP_TICK, '0);
        push_word(OP_ACQUIRE, '0);
        settle();
    endtask

    task automatic test_resync_restart();
        set_config(1'b1, 24'h01_0000, 24'd8);
        push_word(OP_TICK, '0);
        push_word(OP_TICK, '0);
        push_word(OP_RESYNC, '1);
        push_word(OP_TICK, '0);
        push_word(OP_ACQUIRE, '0);
        push_word(OP_RESTART, '1);
        push_word(OP_ACQUIRE, 16'd2);
        settle();
    endtask

    task automatic test_backpressure();
        set_config(1'b1, 24'h02_8000, 24'd40);
        send_gaps   = 1'b0;
        recv_gaps   = 1'b0;
        hold_cycles = 80;
        for (int i = 0; i < 30; i++)
            push_word((i % 2 == 0) ? OP_TICK : OP_ACQUIRE, draw_burst());
        settle();
    endtask

    task automatic test_random();
        logic [RATE_W-1:0] rate;
        logic [LIM_W-1:0]  lim;
        int sel;
        op_t op;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       rate = '0;
                1:       rate = 24'd1;
                2:       rate = '1;
                3, 4:    rate = RATE_W'($urandom_range(1, 24'h04_0000));
                default: rate = RATE_W'($urandom_range(1, 24'hFF_FFFF));
            endcase
            case ($urandom_range(0, 5))
                0:       lim = '0;
                1:       lim = 24'd1;
                2:       lim = '1;
                3, 4:    lim = LIM_W'($urandom_range(1, 300));
                default: lim = LIM_W'($urandom_range(1, 24'hFF_FFFF));
            endcase
            set_config($urandom_range(0, 7) != 0, rate, lim);
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 46)
                    op = OP_TICK;
                else if (sel < 92)
                    op = OP_ACQUIRE;
                else if (sel < 96)
                    op = OP_RESYNC;
                else
                    op = OP_RESTART;
                push_word(op, draw_burst());
            end
            settle();
        end
    endtask

    // result sink with random stall
    initial
    begin
        int k;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                k = hold_cycles;
                hold_cycles = 0;
            end
            else
                k = recv_gaps ? $urandom_range(0, 7) : 0;
            if (k > 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid && hold_cycles == 0)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_queue.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result word %h", $realtime, out_word);
            end
            else
            begin
                want = grant_queue.pop_front();
                if (out_word.granted !== want.granted
                    || out_word.debt_forgiven !== want.debt_forgiven
                    || out_word.issued_total !== want.issued_total
                    || out_word.peak_backlog !== want.peak_backlog
                    || out_word.peak_lateness !== want.peak_lateness
                    || out_word.grant_slots !== want.grant_slots
                    || out_word.forgive_count !== want.forgive_count)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: mismatch granted exp %h got %h, forgiven exp %b got %b",
                                 $realtime, want.granted, out_word.granted,
                                 want.debt_forgiven, out_word.debt_forgiven);
                        $display("  issued exp %h got %h, backlog exp %h got %h",
                                 want.issued_total, out_word.issued_total,
                                 want.peak_backlog, out_word.peak_backlog);
                        $display("  lateness exp %h got %h, slots exp %h got %h",
                                 want.peak_lateness, out_word.peak_lateness,
                                 want.grant_slots, out_word.grant_slots);
                        $display("  forgive count exp %h got %h",
                                 want.forgive_count, out_word.forgive_count);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mismatches  = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        send_gaps   = 1'b1;
        recv_gaps   = 1'b1;

        pacer_cfg.enable         = 1'b0;
        pacer_cfg.rate_per_tick  = '0;
        pacer_cfg.catch_up_limit = 24'd1;
        due_acc     = '0;
        issued_cnt  = '0;
        peak_bl     = '0;
        peak_late   = '0;
        slot_cnt    = '0;
        forgive_cnt = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_disabled();
        test_grants();
        test_forgive();
        test_fraction();
        test_resync_restart();
        test_backpressure();
        test_random();
        settle();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/cpp_pkg.sv
rtl/cpp_cfg.sv
rtl/cpp_engine.sv
rtl/credit_packet_pacer_unit.sv
tb/credit_packet_pacer_unit_tb.sv
